// ===== design/uwb_two_way_ranging_engine_core_macros.svh =====
// assertion macros for the two-way ranging engine
`ifndef UWB_TWO_WAY_RANGING_ENGINE_CORE_MACROS_SVH
`define UWB_TWO_WAY_RANGING_ENGINE_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define UTWR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// antecedent implies consequent in the next cycle
`define UTWR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/utwr_pkg.sv =====
// shared types and constants for the two-way ranging engine
package utwr_pkg;

    localparam int unsigned STAMP_W = 40;
    localparam int unsigned ADDR_W  = 64;
    localparam int unsigned DIFF_W  = 32;
    localparam int unsigned DEN_W   = 34;
    localparam int unsigned NUM_W   = 64;
    localparam int unsigned K_W     = 20;
    localparam int unsigned DVD_W   = NUM_W + K_W;
    localparam int unsigned DIV_STEPS = DVD_W;
    localparam int unsigned CNT_W   = $clog2(DIV_STEPS);

    localparam logic [1:0] OP_RX      = 2'd0;
    localparam logic [1:0] OP_TX      = 2'd1;
    localparam logic [1:0] OP_RX_FAIL = 2'd2;
    localparam logic [1:0] OP_RANGE   = 2'd3;

    localparam logic [7:0] MSG_POLL   = 8'h01;
    localparam logic [7:0] MSG_ANSWER = 8'h02;
    localparam logic [7:0] MSG_FINAL  = 8'h03;
    localparam logic [7:0] MSG_REPORT = 8'h04;

    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_POLL   = 3'd1;
    localparam logic [2:0] KIND_ANSWER = 3'd2;
    localparam logic [2:0] KIND_FINAL  = 3'd3;
    localparam logic [2:0] KIND_REPORT = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_NOT_ADDR  = 3'd2;
    localparam logic [2:0] ST_WRONG_SEQ = 3'd3;
    localparam logic [2:0] ST_WRONG_TAG = 3'd4;
    localparam logic [2:0] ST_BUSY      = 3'd5;
    localparam logic [2:0] ST_ZERO_DIV  = 3'd6;

    localparam logic [1:0] CFG_OWN_ADDR   = 2'd0;
    localparam logic [1:0] CFG_HALF_DELAY = 2'd1;
    localparam logic [1:0] CFG_MM_PER_TICK = 2'd2;

    localparam logic [15:0] HALF_DELAY_RST = 16'd16475;
    localparam logic [K_W-1:0] MM_PER_TICK_RST = 20'd307479;
    localparam logic [15:0] POLL_DEST_HIGH = 16'hBCCF;

    typedef struct packed {
        logic load_in;
        logic eval;
        logic diff;
        logic prod;
        logic num;
        logic mull;
        logic mulh;
        logic div_step;
        logic sat;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic need_range;
        logic range_go;
    } t_stat;

endpackage

// ===== design/uwb_two_way_ranging_engine_core.sv =====
// top level of the two-way ranging engine: controller plus datapath
// usage:
// input channel i_in_valid / o_in_ready carries one radio event item (frame
// received, frame sent, receive failure, range request) with its frame fields.
// output channel o_out_valid / i_out_ready returns exactly one result item per
// input item: frame to transmit, report stamps, re-arm flag, distance, status.
// config writes (i_cfg_we, i_cfg_index, i_cfg_wdata) are registered directly.
// one item is in work at a time. a plain event is latched on acceptance,
// decoded, then loaded into the output register; a report with a zero
// divisor or no positive numerator first forms the stamp differences,
// products and numerator; a full report then adds two scaling multiply steps,
// the 84-step restoring divider (one quotient bit per cycle) and saturation.
// the next item is taken once the result is in the output register.
// when the receiver stalls, the finished result holds in the output register;
// the block still accepts and works the next item, then waits to deliver it.
// synchronous active-low reset clears the exchange state and own address,
// loads the default antenna delay and scale factor, and drops output valid.
module uwb_two_way_ranging_engine_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_index,
    input  logic [63:0]                  i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_op,
    input  logic [6:0]                   i_frame_length,
    input  logic [63:0]                  i_dest_address,
    input  logic [63:0]                  i_source_address,
    input  logic [7:0]                   i_msg_type,
    input  logic [7:0]                   i_msg_seq,
    input  logic [utwr_pkg::STAMP_W-1:0] i_radio_stamp,
    input  logic [utwr_pkg::STAMP_W-1:0] i_in_poll_rx,
    input  logic [utwr_pkg::STAMP_W-1:0] i_in_answer_tx,
    input  logic [utwr_pkg::STAMP_W-1:0] i_in_final_rx,
    input  logic [7:0]                   i_anchor_id,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [2:0]                   o_send_kind,
    output logic [7:0]                   o_send_seq,
    output logic [63:0]                  o_send_dest,
    output logic [utwr_pkg::STAMP_W-1:0] o_out_poll_rx,
    output logic [utwr_pkg::STAMP_W-1:0] o_out_answer_tx,
    output logic [utwr_pkg::STAMP_W-1:0] o_out_final_rx,
    output logic                         o_restart_receive,
    output logic                         o_range_valid,
    output logic [7:0]                   o_range_anchor,
    output logic [31:0]                  o_distance_mm,
    output logic [2:0]                   o_status
);
    import utwr_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    utwr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    utwr_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_op              (i_op),
        .i_frame_length    (i_frame_length),
        .i_dest_address    (i_dest_address),
        .i_source_address  (i_source_address),
        .i_msg_type        (i_msg_type),
        .i_msg_seq         (i_msg_seq),
        .i_radio_stamp     (i_radio_stamp),
        .i_in_poll_rx      (i_in_poll_rx),
        .i_in_answer_tx    (i_in_answer_tx),
        .i_in_final_rx     (i_in_final_rx),
        .i_anchor_id       (i_anchor_id),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_send_kind       (o_send_kind),
        .o_send_seq        (o_send_seq),
        .o_send_dest       (o_send_dest),
        .o_out_poll_rx     (o_out_poll_rx),
        .o_out_answer_tx   (o_out_answer_tx),
        .o_out_final_rx    (o_out_final_rx),
        .o_restart_receive (o_restart_receive),
        .o_range_valid     (o_range_valid),
        .o_range_anchor    (o_range_anchor),
        .o_distance_mm     (o_distance_mm),
        .o_status          (o_status)
    );

`include "uwb_two_way_ranging_engine_core_macros.svh"

    `UTWR_ASSERT_NEXT(a_one_item_in_work, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `UTWR_ASSERT_SAME(a_range_sends_nothing, i_clk, i_rst_n, o_out_valid && o_range_valid, o_send_kind == KIND_NONE)
    `UTWR_ASSERT_SAME(a_stamps_only_in_report, i_clk, i_rst_n, o_out_valid && (o_send_kind != KIND_REPORT), o_out_poll_rx == '0)
    `UTWR_ASSERT_SAME(a_zero_div_no_range, i_clk, i_rst_n, o_out_valid && (o_status == ST_ZERO_DIV), !o_range_valid)

endmodule

// ===== design/utwr_ctrl.sv =====
// controller state machine sequencing event decode, products and division
module utwr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  utwr_pkg::t_stat i_stat,
    output utwr_pkg::t_cmd  o_cmd
);
    import utwr_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EVAL = 4'd1;
    localparam logic [3:0] S_DIFF = 4'd2;
    localparam logic [3:0] S_PROD = 4'd3;
    localparam logic [3:0] S_NUM  = 4'd4;
    localparam logic [3:0] S_MULL = 4'd5;
    localparam logic [3:0] S_MULH = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_SAT  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    t_cmd             cmd;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        cmd         = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_in = 1'b1;
                    n_state     = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval = 1'b1;
                n_state  = i_stat.need_range ? S_DIFF : S_FIN;
            end
            S_DIFF: begin
                cmd.diff = 1'b1;
                n_state  = S_PROD;
            end
            S_PROD: begin
                cmd.prod = 1'b1;
                n_state  = S_NUM;
            end
            S_NUM: begin
                cmd.num = 1'b1;
                n_state = i_stat.range_go ? S_MULL : S_FIN;
            end
            S_MULL: begin
                cmd.mull = 1'b1;
                n_state  = S_MULH;
            end
            S_MULH: begin
                cmd.mulh = 1'b1;
                n_cnt    = '0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                cmd.sat = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.emit    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ===== design/utwr_datapath.sv =====
// datapath: config, exchange state, event decode, products and restoring divider
module utwr_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_index,
    input  logic [63:0]                       i_cfg_wdata,
    input  logic [1:0]                        i_op,
    input  logic [6:0]                        i_frame_length,
    input  logic [63:0]                       i_dest_address,
    input  logic [63:0]                       i_source_address,
    input  logic [7:0]                        i_msg_type,
    input  logic [7:0]                        i_msg_seq,
    input  logic [utwr_pkg::STAMP_W-1:0]      i_radio_stamp,
    input  logic [utwr_pkg::STAMP_W-1:0]      i_in_poll_rx,
    input  logic [utwr_pkg::STAMP_W-1:0]      i_in_answer_tx,
    input  logic [utwr_pkg::STAMP_W-1:0]      i_in_final_rx,
    input  logic [7:0]                        i_anchor_id,
    input  utwr_pkg::t_cmd                    i_cmd,
    output utwr_pkg::t_stat                   o_stat,
    output logic [2:0]                        o_send_kind,
    output logic [7:0]                        o_send_seq,
    output logic [63:0]                       o_send_dest,
    output logic [utwr_pkg::STAMP_W-1:0]      o_out_poll_rx,
    output logic [utwr_pkg::STAMP_W-1:0]      o_out_answer_tx,
    output logic [utwr_pkg::STAMP_W-1:0]      o_out_final_rx,
    output logic                              o_restart_receive,
    output logic                              o_range_valid,
    output logic [7:0]                        o_range_anchor,
    output logic [31:0]                       o_distance_mm,
    output logic [2:0]                        o_status
);
    import utwr_pkg::*;

    // configuration
    logic [ADDR_W-1:0] r_own_addr;
    logic [15:0]       r_half_delay;
    logic [K_W-1:0]    r_k;

    // latched item
    logic [1:0]         r_op;
    logic [6:0]         r_flen;
    logic [63:0]        r_dst, r_src;
    logic [7:0]         r_mtype, r_mseq, r_anchor;
    logic [STAMP_W-1:0] r_stamp, r_in_prx, r_in_atx, r_in_frx;

    // exchange state
    logic [STAMP_W-1:0] r_poll_sent, r_poll_got, r_ans_sent, r_ans_got;
    logic [STAMP_W-1:0] r_fin_sent, r_fin_got;
    logic [2:0]         r_last_kind;
    logic [7:0]         r_tag, r_exseq;
    logic               r_busy;

    // pending result
    logic [2:0]         r_res_kind, r_res_status;
    logic [7:0]         r_res_seq, r_res_anchor;
    logic [63:0]        r_res_dest;
    logic [STAMP_W-1:0] r_res_prx, r_res_atx, r_res_frx;
    logic               r_res_restart, r_res_rvalid;
    logic [31:0]        r_res_dist;

    // range arithmetic
    logic [DIFF_W-1:0] r_tround1, r_treply1, r_tround2, r_treply2;
    logic [DEN_W-1:0]  r_den;
    logic [NUM_W-1:0]  r_p1, r_p2, r_num;
    logic [DVD_W-1:0]  r_dvd;
    logic [DEN_W:0]    r_rem;

    logic [STAMP_W-1:0] got_stamp, sent_stamp;
    logic [7:0]         srcb;
    logic               rx_ok, is_report;
    logic [DEN_W:0]     div_trial;
    logic [DEN_W:0]     div_diff;
    logic [DIFF_W-1:0]      mul_op;
    logic [DIFF_W+K_W-1:0]  mul_part;

    assign got_stamp  = r_stamp - STAMP_W'(r_half_delay);
    assign sent_stamp = r_stamp + STAMP_W'(r_half_delay);
    assign srcb       = r_src[7:0];
    assign rx_ok      = (r_op == OP_RX) && (r_flen != '0) && (r_dst == r_own_addr);
    assign is_report  = rx_ok && (r_mtype == MSG_REPORT) && (r_mseq == r_exseq);

    assign o_stat.need_range = is_report;
    assign o_stat.range_go   = (r_den != '0) && (r_p1 > r_p2);

    assign div_trial = {r_rem[DEN_W-1:0], r_dvd[DVD_W-1]};
    assign div_diff  = div_trial - (DEN_W+1)'(r_den);

    // one 32 x 20 multiplier shared by the low and high scaling steps
    assign mul_op   = i_cmd.mulh ? r_num[NUM_W-1:DIFF_W] : r_num[DIFF_W-1:0];
    assign mul_part = (DIFF_W+K_W)'(mul_op) * (DIFF_W+K_W)'(r_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr   <= '0;
            r_half_delay <= HALF_DELAY_RST;
            r_k          <= MM_PER_TICK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OWN_ADDR:    r_own_addr   <= i_cfg_wdata;
                CFG_HALF_DELAY:  r_half_delay <= i_cfg_wdata[15:0];
                CFG_MM_PER_TICK: r_k          <= i_cfg_wdata[K_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op     <= i_op;
            r_flen   <= i_frame_length;
            r_dst    <= i_dest_address;
            r_src    <= i_source_address;
            r_mtype  <= i_msg_type;
            r_mseq   <= i_msg_seq;
            r_stamp  <= i_radio_stamp;
            r_in_prx <= i_in_poll_rx;
            r_in_atx <= i_in_answer_tx;
            r_in_frx <= i_in_final_rx;
            r_anchor <= i_anchor_id;
        end
    end

    // event decode and exchange state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_sent <= '0;
            r_poll_got  <= '0;
            r_ans_sent  <= '0;
            r_ans_got   <= '0;
            r_fin_sent  <= '0;
            r_fin_got   <= '0;
            r_last_kind <= KIND_NONE;
            r_tag       <= '0;
            r_exseq     <= '0;
            r_busy      <= 1'b0;
        end else if (i_cmd.eval) begin
            r_res_kind    <= KIND_NONE;
            r_res_status  <= ST_OK;
            r_res_seq     <= '0;
            r_res_dest    <= '0;
            r_res_prx     <= '0;
            r_res_atx     <= '0;
            r_res_frx     <= '0;
            r_res_restart <= 1'b0;
            r_res_rvalid  <= 1'b0;
            r_res_anchor  <= '0;
            r_res_dist    <= '0;
            case (r_op)
                OP_TX: begin
                    case (r_last_kind)
                        KIND_POLL:   r_poll_sent <= sent_stamp;
                        KIND_ANSWER: r_ans_sent  <= sent_stamp;
                        KIND_FINAL:  r_fin_sent  <= sent_stamp;
                        default: ;
                    endcase
                end
                OP_RX_FAIL: begin
                    r_res_restart <= 1'b1;
                    r_busy        <= 1'b0;
                end
                OP_RANGE: begin
                    if (r_busy) begin
                        r_res_status <= ST_BUSY;
                    end else begin
                        r_exseq     <= r_exseq + 8'd1;
                        r_res_kind  <= KIND_POLL;
                        r_res_seq   <= r_exseq + 8'd1;
                        r_res_dest  <= {POLL_DEST_HIGH, 40'd0, r_anchor};
                        r_last_kind <= KIND_POLL;
                        r_busy      <= 1'b1;
                    end
                end
                default: begin
                    if (r_flen == '0) begin
                        r_res_status <= ST_EMPTY;
                    end else if (r_dst != r_own_addr) begin
                        r_res_restart <= 1'b1;
                        r_res_status  <= ST_NOT_ADDR;
                    end else begin
                        case (r_mtype)
                            MSG_POLL: begin
                                r_tag       <= srcb;
                                r_poll_got  <= got_stamp;
                                r_res_kind  <= KIND_ANSWER;
                                r_res_seq   <= r_mseq;
                                r_res_dest  <= r_src;
                                r_last_kind <= KIND_ANSWER;
                            end
                            MSG_ANSWER: begin
                                if (r_mseq != r_exseq) begin
                                    r_res_status <= ST_WRONG_SEQ;
                                end else begin
                                    r_ans_got   <= got_stamp;
                                    r_res_kind  <= KIND_FINAL;
                                    r_res_seq   <= r_mseq;
                                    r_res_dest  <= r_src;
                                    r_last_kind <= KIND_FINAL;
                                end
                            end
                            MSG_FINAL: begin
                                if (r_tag != srcb) begin
                                    r_res_restart <= 1'b1;
                                    r_res_status  <= ST_WRONG_TAG;
                                end else begin
                                    r_fin_got   <= got_stamp;
                                    r_res_kind  <= KIND_REPORT;
                                    r_res_seq   <= r_mseq;
                                    r_res_dest  <= r_src;
                                    r_res_prx   <= r_poll_got;
                                    r_res_atx   <= r_ans_sent;
                                    r_res_frx   <= got_stamp;
                                    r_last_kind <= KIND_REPORT;
                                end
                            end
                            MSG_REPORT: begin
                                if (r_mseq != r_exseq) begin
                                    r_res_status <= ST_WRONG_SEQ;
                                end else begin
                                    r_poll_got   <= r_in_prx;
                                    r_ans_sent   <= r_in_atx;
                                    r_fin_got    <= r_in_frx;
                                    r_busy       <= 1'b0;
                                    r_res_rvalid <= 1'b1;
                                    r_res_anchor <= srcb;
                                end
                            end
                            default: begin
                                r_busy <= 1'b0;
                            end
                        endcase
                    end
                end
            endcase
        end else if (i_cmd.num) begin
            if (r_den == '0) begin
                r_res_status <= ST_ZERO_DIV;
                r_res_rvalid <= 1'b0;
                r_res_anchor <= '0;
            end
        end else if (i_cmd.sat) begin
            r_res_dist <= (r_dvd[DVD_W-1:48] != '0) ? 32'hFFFF_FFFF : r_dvd[47:16];
        end
    end

    // stamp differences, products, scaling and division
    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            r_tround1 <= r_ans_got[DIFF_W-1:0] - r_poll_sent[DIFF_W-1:0];
            r_treply1 <= r_ans_sent[DIFF_W-1:0] - r_poll_got[DIFF_W-1:0];
            r_tround2 <= r_fin_got[DIFF_W-1:0] - r_ans_sent[DIFF_W-1:0];
            r_treply2 <= r_fin_sent[DIFF_W-1:0] - r_ans_got[DIFF_W-1:0];
        end
        if (i_cmd.prod) begin
            r_p1  <= NUM_W'(r_tround1) * NUM_W'(r_tround2);
            r_p2  <= NUM_W'(r_treply1) * NUM_W'(r_treply2);
            r_den <= DEN_W'(r_tround1) + DEN_W'(r_tround2)
                   + DEN_W'(r_treply1) + DEN_W'(r_treply2);
        end
        if (i_cmd.num) begin
            r_num <= r_p1 - r_p2;
        end
        if (i_cmd.mull) begin
            r_dvd <= DVD_W'(mul_part);
        end else if (i_cmd.mulh) begin
            r_dvd <= r_dvd + {mul_part, {DIFF_W{1'b0}}};
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            if (!div_diff[DEN_W]) begin
                r_rem <= div_diff;
                r_dvd <= {r_dvd[DVD_W-2:0], 1'b1};
            end else begin
                r_rem <= div_trial;
                r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_send_kind       <= r_res_kind;
            o_send_seq        <= r_res_seq;
            o_send_dest       <= r_res_dest;
            o_out_poll_rx     <= r_res_prx;
            o_out_answer_tx   <= r_res_atx;
            o_out_final_rx    <= r_res_frx;
            o_restart_receive <= r_res_restart;
            o_range_valid     <= r_res_rvalid;
            o_range_anchor    <= r_res_anchor;
            o_distance_mm     <= r_res_dist;
            o_status          <= r_res_status;
        end
    end

endmodule
